FILE: rtl/core/vptw_pkg.sv
// shared types and constants for the vertex window projection pipeline
package vptw_pkg;

    // quotient bits kept by the divider; a larger quotient always saturates
    localparam int QW     = 43;
    // transformed coordinate width, remainder width, scaled numerator width
    localparam int AW     = 49;
    localparam int RW     = 50;
    localparam int MW     = 65;
    // width of the signed sum ahead of the final clamp
    localparam int SW     = QW + 3;

    // pipeline depths
    localparam int XF_LAT = 2;
    localparam int AX_LAT = QW + 4;
    localparam int LAT    = XF_LAT + AX_LAT;

    // configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_ROW0     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_ROW1     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_ROW2     = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_ROW3     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_VIEWPORT = 3'd4;

    // reset values: identity matrix, origin 0,0, 640 by 480
    localparam logic [63:0] RST_ROW0     = 64'h0000_0000_0000_1000;
    localparam logic [63:0] RST_ROW1     = 64'h0000_0000_1000_0000;
    localparam logic [63:0] RST_ROW2     = 64'h0000_1000_0000_0000;
    localparam logic [63:0] RST_ROW3     = 64'h1000_0000_0000_0000;
    localparam logic [63:0] RST_VIEWPORT = 64'h01E0_0280_0000_0000;

    typedef logic signed [AW-1:0] t_acc;

endpackage

FILE: rtl/core/vptw_xform.sv
// matrix times point: product stage then accumulate stage
module vptw_xform #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  logic signed [31:0]  i_point_z,
    input  logic [63:0]         i_mat [4],
    output vptw_pkg::t_acc      o_acc [4]
);

    logic signed [31:0]          w_pt   [3];
    logic signed [15:0]          w_ent  [4][4];
    logic signed [47:0]          r_prod [4][3];
    vptw_pkg::t_acc              r_bias [4];
    vptw_pkg::t_acc              r_acc  [4];

    // unpack matrix entries
    always_comb begin
        w_pt[0] = i_point_x;
        w_pt[1] = i_point_y;
        w_pt[2] = i_point_z;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_ent[r][c] = $signed(i_mat[r][16*c +: 16]);
            end
        end
    end

    // products and translation term
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= w_ent[r][c] * w_pt[c];
                end
                r_bias[r] <= vptw_pkg::AW'(w_ent[r][3]) <<< COORD_FRAC_BITS;
            end
        end
    end

    // row sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r_acc[r] <= vptw_pkg::AW'(r_prod[r][0]) + vptw_pkg::AW'(r_prod[r][1])
                          + vptw_pkg::AW'(r_prod[r][2]) + r_bias[r];
            end
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: rtl/core/vptw_div_axis.sv
// one output axis: (v+w)*scale*2^F/(2w) by a pipelined restoring divider, then offset and clamp
module vptw_div_axis #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  vptw_pkg::t_acc      i_v,
    input  vptw_pkg::t_acc      i_w,
    input  logic [15:0]         i_scale,
    input  logic [15:0]         i_origin,
    output logic [31:0]         o_result
);

    localparam int QW = vptw_pkg::QW;
    localparam int RW = vptw_pkg::RW;
    localparam int MW = vptw_pkg::MW;
    localparam int SW = vptw_pkg::SW;
    localparam int NW = MW + COORD_FRAC_BITS;
    localparam logic signed [SW-1:0] SAT_HI = SW'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sh0000_0000_8000_0000);

    // prep stage signals
    logic signed [vptw_pkg::AW:0] w_sum;
    logic [vptw_pkg::AW-1:0]      w_abs_w;
    logic [vptw_pkg::AW-1:0]      r1_ms;
    logic [RW-1:0]                r1_d;
    logic                         r1_neg, r1_zero;

    logic [MW-1:0]                r2_m;
    logic [RW-1:0]                r2_d;
    logic                         r2_neg, r2_zero;

    logic [NW-1:0]                w_full;
    logic [RW-1:0]                w_init;

    // divider line, entry 0 is the loaded numerator
    logic [RW-1:0]                r_rem  [QW+1];
    logic [QW-1:0]                r_low  [QW+1];
    logic [QW-1:0]                r_q    [QW+1];
    logic [RW-1:0]                r_d    [QW+1];
    logic                         r_neg  [QW+1];
    logic                         r_ovf  [QW+1];
    logic                         r_zero [QW+1];

    logic [RW-1:0]                n_rem  [QW];
    logic [QW-1:0]                n_q    [QW];
    logic [RW:0]                  w_trial[QW];

    logic [QW-1:0]                w_mag;
    logic signed [SW-1:0]         w_smag, w_org, w_tot;
    logic [31:0]                  n_result;
    logic [31:0]                  r_result;

    // sign and magnitudes
    always_comb begin
        w_sum   = (vptw_pkg::AW+1)'(i_v) + (vptw_pkg::AW+1)'(i_w);
        w_abs_w = i_w[vptw_pkg::AW-1] ? vptw_pkg::AW'(-i_w) : vptw_pkg::AW'(i_w);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ms   <= w_sum[vptw_pkg::AW] ? vptw_pkg::AW'(-w_sum) : vptw_pkg::AW'(w_sum);
            r1_d    <= {w_abs_w, 1'b0};
            r1_neg  <= w_sum[vptw_pkg::AW] ^ i_w[vptw_pkg::AW-1];
            r1_zero <= (i_w == '0);
        end
    end

    // scale by viewport size
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_m    <= r1_ms * i_scale;
            r2_d    <= r1_d;
            r2_neg  <= r1_neg;
            r2_zero <= r1_zero;
        end
    end

    // load divider, flag quotients past the kept width
    always_comb begin
        w_full = {r2_m, {COORD_FRAC_BITS{1'b0}}};
        w_init = RW'(w_full >> QW);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_init;
            r_low[0]  <= w_full[QW-1:0];
            r_q[0]    <= '0;
            r_d[0]    <= r2_d;
            r_neg[0]  <= r2_neg;
            r_ovf[0]  <= (w_init >= r2_d);
            r_zero[0] <= r2_zero;
        end
    end

    // one quotient bit per stage
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            w_trial[k] = {r_rem[k], r_low[k][QW-1]};
            if (w_trial[k] >= {1'b0, r_d[k]}) begin
                n_rem[k] = RW'(w_trial[k] - {1'b0, r_d[k]});
                n_q[k]   = {r_q[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k] = w_trial[k][RW-1:0];
                n_q[k]   = {r_q[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_low[k+1]  <= {r_low[k][QW-2:0], 1'b0};
                r_q[k+1]    <= n_q[k];
                r_d[k+1]    <= r_d[k];
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    // sign, origin offset and clamp; zero result when w is zero
    always_comb begin
        w_mag  = r_ovf[QW] ? '1 : r_q[QW];
        w_smag = SW'(signed'({1'b0, w_mag}));
        if (r_neg[QW]) begin
            w_smag = -w_smag;
        end
        w_org  = SW'(signed'({1'b0, i_origin})) <<< COORD_FRAC_BITS;
        w_tot  = w_smag + w_org;
        if (r_zero[QW]) begin
            n_result = '0;
        end else if (w_tot > SAT_HI) begin
            n_result = SAT_HI[31:0];
        end else if (w_tot < SAT_LO) begin
            n_result = SAT_LO[31:0];
        end else begin
            n_result = w_tot[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

FILE: rtl/core/vertex_project_to_window.sv
// Projects a world point through a 4x4 matrix and viewport into window coordinates.
// The block takes one word per clock and returns one word per clock unless the output is held.
// It has a product and a sum stage for the matrix, stages that form the magnitudes, scale
// the numerator and load the divider, 43 restoring divider stages (one quotient bit per
// stage, three dividers side by side) and the origin offset and clamp register. When the
// output word is held by i_stall the whole pipeline halts and o_stall rises; nothing is
// lost or repeated. Configuration writes take effect at once and are meant for idle times.
module vertex_project_to_window #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [31:0]                i_point_x,
    input  logic signed [31:0]                i_point_y,
    input  logic signed [31:0]                i_point_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [31:0]                o_window_x,
    output logic signed [31:0]                o_window_y,
    output logic signed [31:0]                o_window_z,
    output logic                              o_projected_ok,
    input  logic                              i_cfg_we,
    input  logic [vptw_pkg::CFG_IW-1:0]       i_cfg_idx,
    input  logic [63:0]                       i_cfg_data
);

    localparam int LAT    = vptw_pkg::LAT;
    localparam int AX_LAT = vptw_pkg::AX_LAT;
    localparam int XF_LAT = vptw_pkg::XF_LAT;

    logic [63:0]            r_mat [4];
    logic [63:0]            r_vp;
    logic [LAT-1:0]         r_vld;
    logic [AX_LAT-1:0]      r_ok;
    logic                   w_en;
    vptw_pkg::t_acc         w_acc [4];
    logic [31:0]            w_res [3];

    // pipeline moves unless the output word is held
    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= vptw_pkg::RST_ROW0;
            r_mat[1] <= vptw_pkg::RST_ROW1;
            r_mat[2] <= vptw_pkg::RST_ROW2;
            r_mat[3] <= vptw_pkg::RST_ROW3;
            r_vp     <= vptw_pkg::RST_VIEWPORT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vptw_pkg::CFG_ROW0:     r_mat[0] <= i_cfg_data;
                vptw_pkg::CFG_ROW1:     r_mat[1] <= i_cfg_data;
                vptw_pkg::CFG_ROW2:     r_mat[2] <= i_cfg_data;
                vptw_pkg::CFG_ROW3:     r_mat[3] <= i_cfg_data;
                vptw_pkg::CFG_VIEWPORT: r_vp     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid line and w-nonzero flag line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ok <= {r_ok[AX_LAT-2:0], (w_acc[3] != '0)};
        end
    end

    // matrix transform
    vptw_xform #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_xform (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_mat     (r_mat),
        .o_acc     (w_acc)
    );

    // per-axis divide and viewport map
    vptw_div_axis #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_div_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_v      (w_acc[0]),
        .i_w      (w_acc[3]),
        .i_scale  (r_vp[47:32]),
        .i_origin (r_vp[15:0]),
        .o_result (w_res[0])
    );

    vptw_div_axis #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_div_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_v      (w_acc[1]),
        .i_w      (w_acc[3]),
        .i_scale  (r_vp[63:48]),
        .i_origin (r_vp[31:16]),
        .o_result (w_res[1])
    );

    vptw_div_axis #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_div_z (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_v      (w_acc[2]),
        .i_w      (w_acc[3]),
        .i_scale  (16'd1),
        .i_origin (16'd0),
        .o_result (w_res[2])
    );

    assign o_valid        = r_vld[LAT-1];
    assign o_window_x     = $signed(w_res[0]);
    assign o_window_y     = $signed(w_res[1]);
    assign o_window_z     = $signed(w_res[2]);
    assign o_projected_ok = r_ok[AX_LAT-1];

`ifndef SYNTHESIS
    // a failed projection carries zero coordinates
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_projected_ok) |-> (o_window_x == 0 && o_window_y == 0
                                          && o_window_z == 0))
        else $error("failed projection with nonzero coordinates");

    // a held output word stalls the input side
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input not stalled while output held");

    // the valid line freezes while stalled
    a_line_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && $past(i_rst_n)) |=> $stable(r_vld))
        else $error("valid line moved during stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule
